@@ rtl/core/pca_pkg.sv @@
// Shared types and constants for the PID controller with integral clamp.
// Used by pca_ctrl, pca_dp and pid_controller_antiwindup_top; no dependencies.
`default_nettype none
package pca_pkg;

    // multiply pass selects
    localparam logic [1:0] OP_P  = 2'd0;
    localparam logic [1:0] OP_I  = 2'd1;
    localparam logic [1:0] OP_D1 = 2'd2;
    localparam logic [1:0] OP_D2 = 2'd3;

    // configuration register indexes
    localparam int CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_INTEG_GAIN = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_DERIV_GAIN = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_INT_LIMIT  = 3'd3;
    localparam int CfgDataW = 47;

    localparam logic [46:0] LIMIT_RESET = {47{1'b1}};
    localparam logic signed [33:0] MICROS_PER_SEC = 34'sd1000000;

    localparam int DivSteps = 69;
    localparam logic [6:0] DIV_LAST = 7'(DivSteps - 1);

    typedef struct packed {
        logic       load;      // latch input beat
        logic       prep;      // form difference and raw accumulator sum
        logic       acc;       // saturate/clamp accumulator, update previous error
        logic       mul_en;    // one partial product
        logic [1:0] op;
        logic [1:0] chunk;
        logic       store;     // move finished product to its destination
        logic       div_step;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic delta_zero;
    } status_t;

endpackage
`default_nettype wire

@@ rtl/core/pca_ctrl.sv @@
// Sequencer for the PID datapath: multiply passes, divider steps, output handoff.
// Depends on pca_pkg.
`default_nettype none
module pca_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    input  wire pca_pkg::status_t sts,
    output pca_pkg::cmd_t       cmd
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP  = 3'd1;
    localparam logic [2:0] ST_ACC   = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_STORE = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_SUM   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [1:0] op_reg, op_next;
    logic [1:0] chunk_reg, chunk_next;
    logic [6:0] cnt_reg, cnt_next;
    logic       mvalid_reg, mvalid_next;
    logic       out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;
    assign out_free = !mvalid_reg || m_tready;

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        chunk_next  = chunk_reg;
        cnt_next    = cnt_reg;
        mvalid_next = mvalid_reg && !m_tready;
        cmd          = '0;
        cmd.op       = op_reg;
        cmd.chunk    = chunk_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc    = 1'b1;
                op_next    = pca_pkg::OP_P;
                chunk_next = 2'd0;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                chunk_next = chunk_reg + 2'd1;
                if (chunk_reg == 2'd3) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                cmd.store = 1'b1;
                if (op_reg == pca_pkg::OP_D2) begin
                    cnt_next   = '0;
                    state_next = sts.delta_zero ? ST_SUM : ST_DIV;
                end else begin
                    op_next    = op_reg + 2'd1;
                    chunk_next = 2'd0;
                    state_next = ST_MUL;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 7'd1;
                if (cnt_reg == pca_pkg::DIV_LAST) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    mvalid_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            op_reg     <= '0;
            chunk_reg  <= '0;
            cnt_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            chunk_reg  <= chunk_next;
            cnt_reg    <= cnt_next;
            mvalid_reg <= mvalid_next;
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/pca_dp.sv @@
// PID datapath: gain registers, state, shared 34x17 multiplier, restoring divider.
// Depends on pca_pkg; sequenced by pca_ctrl.
`default_nettype none
module pca_dp (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [pca_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire logic [pca_pkg::CfgDataW-1:0]  cfg_data,
    input  wire logic [95:0]                   s_tdata,
    input  wire pca_pkg::cmd_t                 cmd,
    output pca_pkg::status_t                   sts,
    output logic [191:0]                       m_tdata
);
    localparam logic signed [47:0] SAT_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] SAT_MIN = {1'b1, {47{1'b0}}};

    function automatic logic signed [47:0] sat48(input logic signed [97:0] v);
        logic [50:0] top;
        top = v[97:47];
        if (&top || ~|top) return v[47:0];
        return v[97] ? SAT_MIN : SAT_MAX;
    endfunction

    logic signed [31:0] kp_reg, ki_reg, kd_reg;
    logic [46:0]        limit_reg;
    logic signed [32:0] prev_reg, err_reg;
    logic signed [47:0] accum_reg;
    logic signed [33:0] diff_reg;
    logic signed [48:0] sum_reg;
    logic [31:0]        delta_reg;
    logic               dz_reg;
    logic signed [97:0] prod_reg;
    logic signed [47:0] p_reg, i_reg;
    logic signed [49:0] t_reg;
    logic               neg_reg;
    logic [68:0]        dq_reg;
    logic [31:0]        rem_reg;
    logic [191:0]       out_reg;
    logic signed [47:0] acc_sat, acc_next;
    logic signed [48:0] lim_pos, lim_neg;

    // configuration and integrator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg    <= '0;
            ki_reg    <= '0;
            kd_reg    <= '0;
            limit_reg <= pca_pkg::LIMIT_RESET;
            prev_reg  <= '0;
            accum_reg <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    pca_pkg::REG_PROP_GAIN:  kp_reg    <= cfg_data[31:0];
                    pca_pkg::REG_INTEG_GAIN: ki_reg    <= cfg_data[31:0];
                    pca_pkg::REG_DERIV_GAIN: kd_reg    <= cfg_data[31:0];
                    pca_pkg::REG_INT_LIMIT:  limit_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.acc) begin
                accum_reg <= acc_next;
                prev_reg  <= err_reg;
            end
        end
    end

    // accumulator saturate, then clamp to the limit when ki is nonzero
    always_comb begin
        lim_pos = $signed({2'b00, limit_reg});
        lim_neg = -lim_pos;
        if (sum_reg[48] != sum_reg[47]) acc_sat = sum_reg[48] ? SAT_MIN : SAT_MAX;
        else acc_sat = sum_reg[47:0];
        acc_next = acc_sat;
        if (ki_reg != 32'sd0) begin
            if ($signed({acc_sat[47], acc_sat}) > lim_pos) acc_next = lim_pos[47:0];
            if ($signed({acc_sat[47], acc_sat}) < lim_neg) acc_next = lim_neg[47:0];
        end
    end

    // shared multiplier: signed a times b, b taken 16 bits per cycle
    logic signed [33:0] mul_a;
    logic [63:0]        mul_b;
    logic signed [16:0] chunk_s;
    logic signed [50:0] pp;
    logic signed [97:0] pp_ext, pp_sh;
    always_comb begin
        case (cmd.op)
            pca_pkg::OP_P: begin
                mul_a = {{2{kp_reg[31]}}, kp_reg};
                mul_b = {{31{err_reg[32]}}, err_reg};
            end
            pca_pkg::OP_I: begin
                mul_a = {{2{ki_reg[31]}}, ki_reg};
                mul_b = {{16{accum_reg[47]}}, accum_reg};
            end
            pca_pkg::OP_D1: begin
                mul_a = {{2{kd_reg[31]}}, kd_reg};
                mul_b = {{30{diff_reg[33]}}, diff_reg};
            end
            default: begin
                mul_a = pca_pkg::MICROS_PER_SEC;
                mul_b = {{14{t_reg[49]}}, t_reg};
            end
        endcase
        chunk_s = {(cmd.chunk == 2'd3) ? mul_b[63] : 1'b0, mul_b[16*cmd.chunk +: 16]};
        pp      = mul_a * chunk_s;
        pp_ext  = {{47{pp[50]}}, pp};
        case (cmd.chunk)
            2'd0:    pp_sh = pp_ext;
            2'd1:    pp_sh = pp_ext <<< 16;
            2'd2:    pp_sh = pp_ext <<< 32;
            default: pp_sh = pp_ext <<< 48;
        endcase
    end

    // restoring divider step
    logic [32:0] trial;
    logic        fits;
    logic [97:0] prod_neg;
    assign trial    = {rem_reg, dq_reg[68]};
    assign fits     = trial >= {1'b0, delta_reg};
    assign prod_neg = -prod_reg;

    // derivative term and total
    logic               ovf;
    logic signed [47:0] d_val;
    logic signed [49:0] tot;
    always_comb begin
        ovf = |dq_reg[68:47];
        if (dz_reg) d_val = '0;
        else if (ovf) d_val = neg_reg ? SAT_MIN : SAT_MAX;
        else if (neg_reg) d_val = -$signed({1'b0, dq_reg[46:0]});
        else d_val = $signed({1'b0, dq_reg[46:0]});
        tot = {{2{p_reg[47]}}, p_reg} + {{2{i_reg[47]}}, i_reg} + {{2{d_val[47]}}, d_val};
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            err_reg   <= $signed({s_tdata[63], s_tdata[63:32]})
                       - $signed({s_tdata[31], s_tdata[31:0]});
            delta_reg <= s_tdata[95:64];
            dz_reg    <= (s_tdata[95:64] == 32'd0);
        end
        if (cmd.prep) begin
            diff_reg <= {err_reg[32], err_reg} - {prev_reg[32], prev_reg};
            sum_reg  <= {accum_reg[47], accum_reg} + {{16{err_reg[32]}}, err_reg};
        end
        if (cmd.mul_en) begin
            prod_reg <= ((cmd.chunk == 2'd0) ? 98'sd0 : prod_reg) + pp_sh;
        end
        if (cmd.store) begin
            case (cmd.op)
                pca_pkg::OP_P:  p_reg <= sat48(prod_reg >>> 16);
                pca_pkg::OP_I:  i_reg <= sat48(prod_reg >>> 16);
                pca_pkg::OP_D1: t_reg <= prod_reg[65:16];
                default: begin
                    neg_reg <= prod_reg[97];
                    dq_reg  <= prod_reg[97] ? prod_neg[68:0] : prod_reg[68:0];
                    rem_reg <= '0;
                end
            endcase
        end
        if (cmd.div_step) begin
            rem_reg <= fits ? 32'(trial - {1'b0, delta_reg}) : trial[31:0];
            dq_reg  <= {dq_reg[67:0], fits};
        end
        if (cmd.out_load) begin
            out_reg <= {d_val, i_reg, p_reg, sat48({{48{tot[49]}}, tot})};
        end
    end

    assign sts.delta_zero = dz_reg;
    assign m_tdata        = out_reg;
endmodule
`default_nettype wire

@@ rtl/core/pid_controller_antiwindup_top.sv @@
// PID controller with integral clamp, Q16.16. One beat in, one beat out.
// A new input beat is taken only in idle, once the previous result is in the output register.
// Each beat runs four passes of the shared 34x17 multiplier, then the 69-step bit-serial
// divider (skipped when elapsed_micros is 0); the output handoff waits on m_tready.
// Reset (aresetn low, synchronous): gains 0, integral_limit all ones, state cleared.
`default_nettype none
module pid_controller_antiwindup_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [pca_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire logic [pca_pkg::CfgDataW-1:0]  cfg_data,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // measured_value[31:0], target_value[63:32], elapsed_micros[95:64]
    input  wire logic [95:0]                   s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // drive_total[47:0], prop_term[95:48], integ_term[143:96], deriv_term[191:144]
    output logic [191:0]                       m_tdata
);
    pca_pkg::cmd_t    cmd;
    pca_pkg::status_t sts;

    assign cfg_ready = 1'b1;

    pca_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pca_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tdata   (m_tdata)
    );
endmodule
`default_nettype wire

@@ verif/tb.sv @@
// Self-checking bench for pid_controller_antiwindup_top: directed table, then random beats.
// Depends on pca_pkg and the RTL top; predicts each result beat in SystemVerilog.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pca_pkg::*;

    localparam longint SatMax = 64'sh00007FFFFFFFFFFF;
    localparam longint SatMin = -SatMax - 1;
    localparam int NumRandom = 1130;
    localparam longint CycleLimit = 1500000;

    typedef struct packed {
        logic signed [47:0] deriv;
        logic signed [47:0] integ;
        logic signed [47:0] prop;
        logic signed [47:0] total;
    } pid_out_t;

    typedef struct {
        logic [31:0] meas;
        logic [31:0] targ;
        logic [31:0] dt;
        bit          has_exp;
        pid_out_t    exp;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [95:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [191:0] m_tdata;

    pid_controller_antiwindup_top dut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // predictor state and registers
    longint kp, ki, kd, ilimit, prev_err, accum;
    pid_out_t expected_q[$];
    int errors = 0;
    longint cycles = 0;
    bit stall_run = 1'b0;

    function automatic longint sat48(longint v);
        if (v > SatMax) return SatMax;
        if (v < SatMin) return SatMin;
        return v;
    endfunction

    // floor(x*y/2^16); 128-bit product so nothing overflows
    function automatic longint q16_mul(longint x, longint y);
        logic signed [127:0] pr;
        pr = $signed(128'(x)) * $signed(128'(y));
        pr = pr >>> 16;
        return longint'(pr);
    endfunction

    function automatic longint deriv_rate(longint t, longint unsigned dt);
        logic [127:0] m, q;
        m = (t < 0) ? 128'(-t) : 128'(t);
        q = (m * 128'd1000000) / 128'(dt);
        if (q > 128'(SatMax)) return (t < 0) ? SatMin : SatMax;
        return (t < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic pid_out_t pid_predict(logic [31:0] meas, logic [31:0] targ,
                                             logic [31:0] dt);
        longint e, a, p, i, d;
        pid_out_t r;
        e = longint'($signed(targ)) - longint'($signed(meas));
        a = sat48(accum + e);
        if (ki != 0) begin
            if (a > ilimit) a = ilimit;
            if (a < -ilimit) a = -ilimit;
        end
        accum = a;
        p = sat48(q16_mul(kp, e));
        i = sat48(q16_mul(ki, a));
        d = (dt == 0) ? 0 : deriv_rate(q16_mul(kd, e - prev_err), longint'(dt));
        prev_err = e;
        r.total = 48'(sat48(p + i + d));
        r.prop = 48'(p);
        r.integ = 48'(i);
        r.deriv = 48'(d);
        return r;
    endfunction

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_PROP_GAIN:  kp = longint'($signed(val[31:0]));
            REG_INTEG_GAIN: ki = longint'($signed(val[31:0]));
            REG_DERIV_GAIN: kd = longint'($signed(val[31:0]));
            REG_INT_LIMIT:  ilimit = longint'(val);
            default: ;
        endcase
    endtask

    task automatic drain_results();
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic send_item(logic [31:0] meas, logic [31:0] targ, logic [31:0] dt);
        s_tdata <= {dt, targ, meas};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        expected_q.push_back(pid_predict(meas, targ, dt));
    endtask

    task automatic set_gains(logic [31:0] p, logic [31:0] i, logic [31:0] d,
                             logic [46:0] lim);
        write_reg(REG_PROP_GAIN, 47'(p));
        write_reg(REG_INTEG_GAIN, 47'(i));
        write_reg(REG_DERIV_GAIN, 47'(d));
        write_reg(REG_INT_LIMIT, lim);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(0, 131072)) - 65536);
            default: return $urandom();
        endcase
    endfunction

    // receiver: mostly-ready with occasional stall runs
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles % 512 == 0) stall_run <= ($urandom_range(0, 2) == 0);
        m_tready <= stall_run ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 9) != 0);
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result beat %h", m_tdata);
                errors++;
            end else begin
                pid_out_t ex, act;
                ex = expected_q.pop_front();
                act = m_tdata;
                if (act.total !== ex.total) begin
                    $error("drive_total exp %h got %h", ex.total, act.total); errors++;
                end
                if (act.prop !== ex.prop) begin
                    $error("prop_term exp %h got %h", ex.prop, act.prop); errors++;
                end
                if (act.integ !== ex.integ) begin
                    $error("integ_term exp %h got %h", ex.integ, act.integ); errors++;
                end
                if (act.deriv !== ex.deriv) begin
                    $error("deriv_term exp %h got %h", ex.deriv, act.deriv); errors++;
                end
            end
        end
        if (cycles > CycleLimit) begin
            $display("FAIL");
            $finish;
        end
    end

    stim_row_t dir_tbl[] = '{
        // gains zero after reset: all terms zero
        '{32'h0001_0000, 32'h0003_0000, 32'd1000, 1'b1, '0},
        '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, '0},
        '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 1'b1, '0},
        '{32'h0000_0000, 32'h0000_0000, 32'd1, 1'b1, '0}
    };

    initial begin
        pid_out_t ex;
        int gap;
        kp = 0; ki = 0; kd = 0; ilimit = SatMax; prev_err = 0; accum = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tbl[n]) begin
            ex = pid_predict(dir_tbl[n].meas, dir_tbl[n].targ, dir_tbl[n].dt);
            if (dir_tbl[n].has_exp && ex !== dir_tbl[n].exp) begin
                $error("directed row %0d table mismatch", n);
                errors++;
            end
            // prediction already taken above; drive the row directly
            s_tdata <= {dir_tbl[n].dt, dir_tbl[n].targ, dir_tbl[n].meas};
            s_tvalid <= 1'b1;
            do @(posedge aclk); while (!s_tready);
            expected_q.push_back(ex);
        end
        s_tvalid <= 1'b0;
        drain_results();

        // extremes: full-scale gains, clamp active, zero dt, max dt
        set_gains(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 47'd0);
        send_item(32'h8000_0000, 32'h7FFF_FFFF, 32'd1);
        send_item(32'h7FFF_FFFF, 32'h8000_0000, 32'd1);
        send_item(32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
        send_item(32'h0, 32'h0001_0000, 32'hFFFF_FFFF);
        s_tvalid <= 1'b0;
        drain_results();
        write_reg(3'd7, '1);   // unknown index: ignored
        set_gains(32'h0001_0000, 32'h0000_8000, 32'h8000_0000, 47'h0000_0002_0000);
        send_item(32'h0, 32'h0005_0000, 32'd100);
        send_item(32'h0, 32'h0005_0000, 32'd0);
        send_item(32'h0005_0000, 32'h0, 32'd1);
        // ki zero: accumulator is not clamped to the limit
        s_tvalid <= 1'b0;
        drain_results();
        set_gains(32'hFFFF_0000, 32'd0, 32'd1, '1);
        repeat (6) send_item(32'h8000_0000, 32'h7FFF_FFFF, 32'd7);
        s_tvalid <= 1'b0;
        drain_results();

        for (int n = 0; n < NumRandom; n++) begin
            if (n % 150 == 0) begin
                s_tvalid <= 1'b0;
                drain_results();   // idle between gain phases
                case ($urandom_range(0, 3))
                    0: set_gains($urandom(), $urandom(), $urandom(),
                                 47'({$urandom(), $urandom()}));
                    1: set_gains(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                 47'($urandom_range(0, 1 << 20)));
                    2: set_gains(32'($urandom_range(0, 1 << 18)), 32'd0,
                                 32'($urandom_range(0, 1 << 18)), '1);
                    default: set_gains(rand_word(), rand_word(), rand_word(),
                                       {15'($urandom()), $urandom()});
                endcase
            end
            send_item(rand_word(), rand_word(),
                      ($urandom_range(0, 7) == 0) ? 32'd0 :
                      ($urandom_range(0, 3) == 0) ? rand_word() :
                      32'($urandom_range(1, 20000)));
            if ($urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 200);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b0;
        drain_results();
        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
